// ----- rtl/core/gbn_pkg.sv -----
// Go-Back-N sender package: request/response structs, mode and timer codes,
// and sequence-space constants. No dependencies.
`timescale 1ns / 1ps

package gbn_pkg;

   // Sequence fields are three bits wide, so the sequence space is fixed.
   localparam int SEQ_SPACE          = 8;
   localparam int SEQ_BITS           = $clog2(SEQ_SPACE);
   localparam int WINDOW_DEF         = 4;
   localparam int PAYLOAD_BITS_DEF   = 64;
   localparam int PAYLOAD_PORT_BITS  = 64;

   localparam logic [1:0] MODE_SEND    = 2'd0;
   localparam logic [1:0] MODE_ACK     = 2'd1;
   localparam logic [1:0] MODE_TIMEOUT = 2'd2;

   typedef enum logic [1:0] {
      TMR_NONE       = 2'd0,
      TMR_START      = 2'd1,
      TMR_STOP       = 2'd2,
      TMR_STOP_START = 2'd3
   } timer_cmd_type;

   typedef struct packed {
      logic [1:0]                   mode;
      logic [PAYLOAD_PORT_BITS-1:0] payload;
      logic [SEQ_BITS-1:0]          ack_number;
      logic                         ack_intact;
      logic [SEQ_BITS-1:0]          expired_seq;
   } req_type;

   typedef struct packed {
      logic                         accepted;
      logic                         tx_valid;
      logic [SEQ_BITS-1:0]          tx_seq;
      logic [PAYLOAD_PORT_BITS-1:0] tx_payload;
      logic                         last;
      timer_cmd_type                timer_cmd;
      logic [SEQ_BITS-1:0]          timer_seq;
      logic [SEQ_BITS-1:0]          window_base;
      logic                         window_full;
   } rsp_type;

endpackage

// ----- rtl/core/go_back_n_sender_top.sv -----
// Go-Back-N sender window: sequence control, payload store, resend sequencer.
// Depends on gbn_pkg.
`timescale 1ns / 1ps

// A request is taken on a clock edge with start high and busy low. Sends,
// acknowledgements and unknown modes give one response each; busy stays
// low, so a new request can follow in the next cycle. A timeout with n
// packets outstanding gives n responses back to back (oldest first, last
// marked, timer command on the first) and holds busy high until the last
// resend is produced: one shared read port of the payload store and one
// sequence incrementer step through the window, one packet per cycle. A
// timeout with nothing outstanding gives a single response. Each response
// appears in the cycle after the one that produced it, on rsp_data for
// exactly one cycle with rsp_strobe high; there is no back-pressure, so
// the receiver must take every response as it comes. window_base and
// window_full always show the state after the request. The effective
// window is WINDOW, limited to SEQ_SPACE-1. Payload store entries have no
// reset; only entries written by a send are ever read.
module go_back_n_sender_top #(
   parameter int WINDOW       = gbn_pkg::WINDOW_DEF,
   parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  gbn_pkg::req_type req_data,
   output logic            rsp_strobe,
   output gbn_pkg::rsp_type rsp_data
);
   import gbn_pkg::*;

   localparam int WIN_EFF = (WINDOW < SEQ_SPACE) ? WINDOW : SEQ_SPACE - 1;

   typedef enum logic {
      ST_IDLE,
      ST_RESEND
   } state_type;

   typedef logic [SEQ_BITS-1:0] seq_type;

   state_type state_ff, state_in;
   seq_type   base_ff, base_in;
   seq_type   next_ff, next_in;
   logic      full_ff, full_in;
   seq_type   cur_ff, cur_in;     // next sequence to resend
   seq_type   left_ff, left_in;   // resends still to emit
   logic      rsp_strobe_ff, rsp_strobe_in;
   rsp_type   rsp_ff, rsp_in;

   // payload store
   logic [PAYLOAD_BITS-1:0] store_mem [SEQ_SPACE];
   logic                    wr_en;

   // shared read port and incrementer
   seq_type rd_seq;
   seq_type rd_inc;
   logic [PAYLOAD_BITS-1:0] rd_data;

   seq_type in_flight;
   seq_type in_flight_new;
   seq_type ack_off;
   seq_type ack_seq;

   assign in_flight     = next_ff - base_ff;
   assign in_flight_new = next_ff + seq_type'(1) - base_ff;
   assign ack_seq       = req_data.ack_number;
   assign ack_off       = ack_seq - base_ff;

   assign rd_seq  = (state_ff == ST_RESEND) ? cur_ff : base_ff;
   assign rd_inc  = rd_seq + seq_type'(1);
   assign rd_data = store_mem[rd_seq];

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      next_in       = next_ff;
      full_in       = full_ff;
      cur_in        = cur_ff;
      left_in       = left_ff;
      rsp_strobe_in = 1'b0;
      wr_en         = 1'b0;
      rsp_in        = '0;
      rsp_in.last   = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_strobe_in = 1'b1;
               unique case (req_data.mode)
                  MODE_SEND: begin
                     if (!full_ff) begin
                        wr_en             = 1'b1;
                        next_in           = next_ff + seq_type'(1);
                        full_in           = (in_flight_new == seq_type'(WIN_EFF));
                        rsp_in.accepted   = 1'b1;
                        rsp_in.tx_valid   = 1'b1;
                        rsp_in.tx_seq     = next_ff;
                        rsp_in.tx_payload =
                           PAYLOAD_PORT_BITS'(req_data.payload[PAYLOAD_BITS-1:0]);
                        if (base_ff == next_ff) begin
                           rsp_in.timer_cmd = TMR_START;
                           rsp_in.timer_seq = next_ff;
                        end
                     end
                  end
                  MODE_ACK: begin
                     if (req_data.ack_intact && (ack_off < in_flight)) begin
                        base_in = ack_seq + seq_type'(1);
                        full_in = 1'b0;
                        if (base_in == next_ff) begin
                           rsp_in.timer_cmd = TMR_STOP;
                           rsp_in.timer_seq = base_ff;
                        end else begin
                           rsp_in.timer_cmd = TMR_STOP_START;
                           rsp_in.timer_seq = base_in;
                        end
                     end
                  end
                  MODE_TIMEOUT: begin
                     rsp_in.timer_cmd = TMR_STOP_START;
                     rsp_in.timer_seq = req_data.expired_seq;
                     if (in_flight != '0) begin
                        // first resend leaves now, the rest from the sequencer
                        rsp_in.tx_valid   = 1'b1;
                        rsp_in.tx_seq     = rd_seq;
                        rsp_in.tx_payload = PAYLOAD_PORT_BITS'(rd_data);
                        rsp_in.last       = (in_flight == seq_type'(1));
                        cur_in            = rd_inc;
                        left_in           = in_flight - seq_type'(1);
                        if (in_flight != seq_type'(1)) begin
                           state_in = ST_RESEND;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RESEND: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.tx_valid   = 1'b1;
            rsp_in.tx_seq     = rd_seq;
            rsp_in.tx_payload = PAYLOAD_PORT_BITS'(rd_data);
            rsp_in.last       = (left_ff == seq_type'(1));
            cur_in            = rd_inc;
            left_in           = left_ff - seq_type'(1);
            if (left_ff == seq_type'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.window_base = base_in;
      rsp_in.window_full = full_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         base_ff       <= '0;
         next_ff       <= '0;
         full_ff       <= 1'b0;
         cur_ff        <= '0;
         left_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         next_ff       <= next_in;
         full_ff       <= full_in;
         cur_ff        <= cur_in;
         left_ff       <= left_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[next_ff] <= req_data.payload[PAYLOAD_BITS-1:0];
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef ASSERT_OFF
   // every taken request produces a response in the next cycle
   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("request without response");

   // the resend sequencer emits one packet per busy cycle
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe)
      else $error("resend cycle without response");

   // full flag only with a full window outstanding
   a_full: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (in_flight == seq_type'(WIN_EFF)))
      else $error("full flag with window not full");

   // a non-final packet means more resends are pending
   a_more: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> busy)
      else $error("non-final response while idle");
`endif

endmodule
